// File: hdl/crce_pkg.sv
`timescale 1ns / 1ps

package crce_pkg;

   localparam int OP_W      = 1;
   localparam int IDX_W     = 5;
   localparam int KNOT_W    = 16;
   localparam int POS_W     = 17;
   localparam int CURVE_W   = 15;
   localparam int CFG_W     = 6;
   localparam int FRAC_BITS = 16;
   localparam int ACC_W     = 24;

   localparam logic [OP_W-1:0]    OP_LOAD   = 1'b0;
   localparam logic [OP_W-1:0]    OP_EVAL   = 1'b1;
   localparam logic [CFG_W-1:0]   CFG_RESET = 6'd7;
   localparam logic [POS_W-1:0]   POS_ONE   = 17'h10000;
   localparam logic [CURVE_W-1:0] CURVE_MAX = 15'd16384;
   localparam int                 ROUND_HALF = 32768;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_ZERO,
      KIND_EVAL
   } crce_kind_type;

   typedef struct packed {
      crce_kind_type             kind;
      logic                      first;
      logic                      last;
      logic signed [KNOT_W-1:0]  value;
      logic [POS_W-1:0]          frac;
   } crce_cmd_type;

endpackage

// File: hdl/crce_ifs.sv
`timescale 1ns / 1ps

interface crce_req_if import crce_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [IDX_W-1:0]         knot_index;
   logic signed [KNOT_W-1:0] knot_value;
   logic [POS_W-1:0]         position;

   modport source (output valid, output op, output knot_index, output knot_value,
                   output position, input ready);
   modport sink   (input valid, input op, input knot_index, input knot_value,
                   input position, output ready);
endinterface

interface crce_rsp_if import crce_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CURVE_W-1:0] curve_value;

   modport source (output valid, output curve_value, input ready);
   modport sink   (input valid, input curve_value, output ready);
endinterface

interface crce_csr_if import crce_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] knot_count;

   modport source (output valid, output knot_count, input ready);
   modport sink   (input valid, input knot_count, output ready);
endinterface

// File: hdl/crce_ram.sv
`timescale 1ns / 1ps

module crce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/crce_fifo.sv
`timescale 1ns / 1ps

module crce_fifo #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 2,
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

endmodule

// File: hdl/crce_front.sv
`timescale 1ns / 1ps

module crce_front import crce_pkg::*; #(
   parameter int MAX_KNOTS = 32,
   localparam int IDX_BITS = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1,
   localparam int CNT_BITS = IDX_BITS + 1
) (
   input  logic                clock,
   input  logic                reset,
   crce_req_if.sink            req_ch,
   input  logic [CNT_BITS-1:0] knot_num,
   output logic                push,
   output crce_cmd_type        push_cmd,
   output logic [IDX_BITS-1:0] push_addr,
   input  logic                full
);

   localparam int X_BITS   = POS_W + CNT_BITS;
   localparam int SEG_BITS = X_BITS - FRAC_BITS;

   logic                     a_valid_ff, a_valid_in;
   logic [OP_W-1:0]          a_op_ff, a_op_in;
   logic [IDX_W-1:0]         a_idx_ff, a_idx_in;
   logic signed [KNOT_W-1:0] a_val_ff, a_val_in;
   logic [POS_W-1:0]         a_pos_ff, a_pos_in;

   logic                     b_valid_ff, b_valid_in;
   logic [OP_W-1:0]          b_op_ff, b_op_in;
   logic [IDX_W-1:0]         b_idx_ff, b_idx_in;
   logic signed [KNOT_W-1:0] b_val_ff, b_val_in;
   logic [X_BITS-1:0]        b_x_ff, b_x_in;

   logic                accept;
   logic                advance;
   logic                needs_push;
   logic [CNT_BITS-1:0] nm1;
   logic [SEG_BITS-1:0] seg;
   logic                at_end;
   logic [IDX_BITS-1:0] i1;
   logic [POS_W-1:0]    frac;
   logic                load_ok;
   logic                too_few;

   assign nm1     = knot_num - CNT_BITS'(1);
   assign seg     = b_x_ff[X_BITS-1:FRAC_BITS];
   assign at_end  = (seg >= SEG_BITS'(nm1));
   assign i1      = at_end ? IDX_BITS'(knot_num - CNT_BITS'(2)) : IDX_BITS'(seg);
   assign frac    = at_end ? POS_ONE : {1'b0, b_x_ff[FRAC_BITS-1:0]};
   assign load_ok = (32'(b_idx_ff) < MAX_KNOTS);
   assign too_few = (knot_num < CNT_BITS'(2));

   assign needs_push = b_valid_ff && ((b_op_ff == OP_EVAL) || load_ok);
   assign advance    = !needs_push || !full;
   assign push       = needs_push && !full;
   assign accept     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !a_valid_ff || advance;

   always_comb begin
      push_cmd.value = b_val_ff;
      push_cmd.frac  = frac;
      push_cmd.first = (i1 == '0);
      push_cmd.last  = (({1'b0, i1} + CNT_BITS'(1)) == nm1);
      if (b_op_ff == OP_LOAD) begin
         push_cmd.kind = KIND_LOAD;
         push_addr     = IDX_BITS'(b_idx_ff);
      end else begin
         push_cmd.kind = too_few ? KIND_ZERO : KIND_EVAL;
         push_addr     = i1;
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      a_op_in    = a_op_ff;
      a_idx_in   = a_idx_ff;
      a_val_in   = a_val_ff;
      a_pos_in   = a_pos_ff;
      b_valid_in = b_valid_ff;
      b_op_in    = b_op_ff;
      b_idx_in   = b_idx_ff;
      b_val_in   = b_val_ff;
      b_x_in     = b_x_ff;
      if (advance) begin
         b_valid_in = a_valid_ff;
         b_op_in    = a_op_ff;
         b_idx_in   = a_idx_ff;
         b_val_in   = a_val_ff;
         b_x_in     = X_BITS'(a_pos_ff) * X_BITS'(nm1);
         a_valid_in = 1'b0;
      end
      if (accept) begin
         a_valid_in = 1'b1;
         a_op_in    = req_ch.op;
         a_idx_in   = req_ch.knot_index;
         a_val_in   = req_ch.knot_value;
         a_pos_in   = (req_ch.position > POS_ONE) ? POS_ONE : req_ch.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_op_ff  <= a_op_in;
      a_idx_ff <= a_idx_in;
      a_val_ff <= a_val_in;
      a_pos_ff <= a_pos_in;
      b_op_ff  <= b_op_in;
      b_idx_ff <= b_idx_in;
      b_val_ff <= b_val_in;
      b_x_ff   <= b_x_in;
   end

endmodule

// File: hdl/crce_back.sv
`timescale 1ns / 1ps

module crce_back import crce_pkg::*; #(
   parameter int MAX_KNOTS = 32,
   localparam int IDX_BITS = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_empty,
   output logic                pop,
   input  crce_cmd_type        pop_cmd,
   input  logic [IDX_BITS-1:0] pop_addr,
   crce_rsp_if.source          rsp_ch
);

   localparam int PROD_W = ACC_W + POS_W + 1;
   localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1);
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(CURVE_MAX);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH1,
      ST_FETCH2,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                step_ff, step_in;
   logic [IDX_BITS-1:0]       addr_ff, addr_in;
   logic                      first_ff, first_in;
   logic                      last_ff, last_in;
   logic [POS_W-1:0]          frac_ff, frac_in;
   logic signed [KNOT_W-1:0]  p1_ff, p1_in;
   logic signed [KNOT_W-1:0]  p2_ff, p2_in;
   logic signed [ACC_W-1:0]   a2_ff, a2_in;
   logic signed [ACC_W-1:0]   a1_ff, a1_in;
   logic signed [ACC_W-1:0]   a0_ff, a0_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CURVE_W-1:0]        curve_ff, curve_in;

   logic                      slot_free;
   logic                      wr_en;
   logic [IDX_BITS-1:0]       rd_addr_a, rd_addr_b;
   logic [KNOT_W-1:0]         rd_data_a, rd_data_b;

   logic signed [ACC_W-1:0]   w0, w1, w2, w3;
   logic signed [ACC_W-1:0]   coef;
   logic signed [PROD_W-1:0]  rounded;
   logic signed [ACC_W-1:0]   half;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign pop = (state_ff == ST_IDLE) && !cmd_empty
                && ((pop_cmd.kind != KIND_ZERO) || slot_free);
   assign wr_en = pop && (pop_cmd.kind == KIND_LOAD);

   assign rd_addr_a = (state_ff == ST_FETCH1) ? addr_ff - IDX_BITS'(1) : pop_addr;
   assign rd_addr_b = (state_ff == ST_FETCH1) ? addr_ff + IDX_BITS'(2)
                                              : pop_addr + IDX_BITS'(1);

   // Two copies of the knot table give two neighbours per cycle.
   crce_ram #(.WIDTH(KNOT_W), .DEPTH(MAX_KNOTS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pop_addr),
      .wr_data (pop_cmd.value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   crce_ram #(.WIDTH(KNOT_W), .DEPTH(MAX_KNOTS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pop_addr),
      .wr_data (pop_cmd.value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   // Neighbours, with reflection at either end.
   assign w1 = ACC_W'(p1_ff);
   assign w2 = ACC_W'(p2_ff);
   assign w0 = first_ff ? (w1 <<< 1) - w2 : ACC_W'($signed(rd_data_a));
   assign w3 = last_ff  ? (w2 <<< 1) - w1 : ACC_W'($signed(rd_data_b));

   always_comb begin
      case (step_ff)
         2'd0:    coef = a2_ff;
         2'd1:    coef = a1_ff;
         default: coef = a0_ff;
      endcase
   end

   assign rounded = (prod_ff + PROD_W'(ROUND_HALF)) >>> FRAC_BITS;
   assign half    = (acc_ff + ACC_ONE) >>> 1;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      addr_in      = addr_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      frac_in      = frac_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      a2_in        = a2_ff;
      a1_in        = a1_ff;
      a0_in        = a0_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      curve_in     = curve_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (pop_cmd.kind == KIND_ZERO) begin
                  rsp_valid_in = 1'b1;
                  curve_in     = '0;
               end else if (pop_cmd.kind == KIND_EVAL) begin
                  addr_in  = pop_addr;
                  first_in = pop_cmd.first;
                  last_in  = pop_cmd.last;
                  frac_in  = pop_cmd.frac;
                  state_in = ST_FETCH1;
               end
            end
         end
         ST_FETCH1: begin
            p1_in    = $signed(rd_data_a);
            p2_in    = $signed(rd_data_b);
            state_in = ST_FETCH2;
         end
         ST_FETCH2: begin
            acc_in   = (w1 + (w1 <<< 1)) - (w2 + (w2 <<< 1)) + w3 - w0;
            a2_in    = (w0 <<< 1) - ((w1 <<< 2) + w1) + (w2 <<< 2) - w3;
            a1_in    = w2 - w0;
            a0_in    = w1 <<< 1;
            step_in  = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = acc_ff * $signed({1'b0, frac_ff});
            state_in = ST_ADD;
         end
         ST_ADD: begin
            acc_in   = ACC_W'(rounded) + coef;
            step_in  = step_ff + 2'd1;
            state_in = (step_ff == 2'd2) ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (half < 0) begin
                  curve_in = '0;
               end else if (half > ACC_MAX) begin
                  curve_in = CURVE_MAX;
               end else begin
                  curve_in = CURVE_W'(half);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff  <= addr_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      frac_ff  <= frac_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      a2_ff    <= a2_in;
      a1_ff    <= a1_in;
      a0_ff    <= a0_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      curve_ff <= curve_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.curve_value = curve_ff;

endmodule

// File: hdl/catmull_rom_curve_eval_unit.sv
`timescale 1ns / 1ps

// Uniform Catmull-Rom curve evaluator over a table of MAX_KNOTS knots.
// req_ch: one beat per item. op load writes knot_value (Q2.14) at knot_index;
//   op eval asks for the curve at position (Q1.16). Loads give no rsp beat.
// rsp_ch: one beat per eval, curve_value clamped to 0..16384 (Q1.14).
// csr_ch: writes knot_count (knots in use); always ready, write only when idle.
// Front stage: two register stages (request capture, index scale multiply) and a
//   segment select feed a two-entry command queue, so req_ch keeps taking beats
//   while the back end works or rsp_ch stalls.
// Back end: a sequencer with one shared multiplier. A load is written to the
//   knot table as it is popped; an eval steps through two knot fetches,
//   coefficients, three Horner multiply/add pairs and rounding.
// Sustained rate: one load per cycle while the back end is idle; evals do not overlap.
// Reset: queue and output empty, knot_count = 7; the knot table is not cleared
//   and a knot must be loaded before any eval reads it.
// A stalled rsp_ch holds its beat; the back end waits, the queue fills, and
// req_ch.ready drops only once the queue and front stages are full.

module catmull_rom_curve_eval_unit import crce_pkg::*; #(
   parameter int MAX_KNOTS = 32
) (
   input  logic       clock,
   input  logic       reset,
   crce_req_if.sink   req_ch,
   crce_rsp_if.source rsp_ch,
   crce_csr_if.sink   csr_ch
);

   localparam int IDX_BITS = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam int Q_WIDTH  = $bits(crce_cmd_type) + IDX_BITS;
   localparam int Q_DEPTH  = 2;

   logic [CFG_W-1:0]    knot_count_ff, knot_count_in;
   logic [CNT_BITS-1:0] knot_num;

   logic                push, pop, full, empty;
   crce_cmd_type        push_cmd, pop_cmd;
   logic [IDX_BITS-1:0] push_addr, pop_addr;
   logic [Q_WIDTH-1:0]  pop_data;

   assign csr_ch.ready  = 1'b1;
   assign knot_count_in = (csr_ch.valid) ? csr_ch.knot_count : knot_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         knot_count_ff <= CFG_RESET;
      end else begin
         knot_count_ff <= knot_count_in;
      end
   end

   assign knot_num = (32'(knot_count_ff) > MAX_KNOTS) ? CNT_BITS'(MAX_KNOTS)
                                                      : CNT_BITS'(knot_count_ff);

   crce_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .knot_num  (knot_num),
      .push      (push),
      .push_cmd  (push_cmd),
      .push_addr (push_addr),
      .full      (full)
   );

   crce_fifo #(.WIDTH(Q_WIDTH), .DEPTH(Q_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_cmd, push_addr}),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   assign pop_cmd  = crce_cmd_type'(pop_data[Q_WIDTH-1:IDX_BITS]);
   assign pop_addr = pop_data[IDX_BITS-1:0];

   crce_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (empty),
      .pop       (pop),
      .pop_cmd   (pop_cmd),
      .pop_addr  (pop_addr),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: tb/sv/crce_tb_pkg.sv
`timescale 1ns / 1ps

package crce_tb_pkg;
   import crce_pkg::*;

   localparam int TB_KNOTS = 32;

   class crce_curve_scoreboard;
      logic signed [KNOT_W-1:0] knot_tab [TB_KNOTS];
      logic [CFG_W-1:0]         knot_count;
      logic [CURVE_W-1:0]       curve_due [$];
      int                       mismatches;

      function new();
         foreach (knot_tab[i]) knot_tab[i] = '0;
         knot_count = CFG_RESET;
         mismatches = 0;
      endfunction

      function void set_count(logic [CFG_W-1:0] n);
         knot_count = n;
      endfunction

      function int pending();
         return curve_due.size();
      endfunction

      // expected curve value for the current table and count
      function automatic logic [CURVE_W-1:0] curve_at(logic [POS_W-1:0] pos);
         int unsigned       n;
         int unsigned       seg;
         longint unsigned   p;
         longint unsigned   scaled;
         longint            frac, k0, k1, k2, k3, c3, c2, c1, c0, acc, r;
         n = (knot_count > TB_KNOTS) ? TB_KNOTS : knot_count;
         if (n < 2) return '0;
         p = pos;
         if (p > POS_ONE) p = POS_ONE;
         scaled = p * (n - 1);
         seg = 32'(scaled >> FRAC_BITS);
         frac = scaled & 64'hFFFF;
         if (seg >= n - 1) begin
            seg = n - 2;
            frac = 65536;
         end
         k1 = knot_tab[seg];
         k2 = knot_tab[seg + 1];
         if (seg == 0) k0 = 2 * k1 - k2;
         else k0 = knot_tab[seg - 1];
         if (seg + 1 == n - 1) k3 = 2 * k2 - k1;
         else k3 = knot_tab[seg + 2];
         c3 = -k0 + 3 * k1 - 3 * k2 + k3;
         c2 = 2 * k0 - 5 * k1 + 4 * k2 - k3;
         c1 = k2 - k0;
         c0 = 2 * k1;
         acc = c3;
         acc = ((acc * frac + ROUND_HALF) >>> FRAC_BITS) + c2;
         acc = ((acc * frac + ROUND_HALF) >>> FRAC_BITS) + c1;
         acc = ((acc * frac + ROUND_HALF) >>> FRAC_BITS) + c0;
         r = (acc + 1) >>> 1;
         if (r < 0) r = 0;
         if (r > CURVE_MAX) r = CURVE_MAX;
         return r[CURVE_W-1:0];
      endfunction

      function void take_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                 logic signed [KNOT_W-1:0] val, logic [POS_W-1:0] pos);
         if (op == OP_LOAD) begin
            if (idx < TB_KNOTS) knot_tab[idx] = val;
         end else begin
            curve_due.insert(curve_due.size(), curve_at(pos));
         end
      endfunction

      task report_mismatch(string what);
         $display("tb_top: mismatch: %s", what);
         mismatches++;
      endtask

      task check_curve(logic [CURVE_W-1:0] got);
         logic [CURVE_W-1:0] want;
         if (curve_due.size() == 0) begin
            report_mismatch($sformatf("curve_value %0d with no eval pending", got));
         end else begin
            want = curve_due.pop_front();
            if (got !== want)
               report_mismatch($sformatf("curve_value %0d, want %0d", got, want));
         end
      endtask
   endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import crce_pkg::*;
   import crce_tb_pkg::*;

   localparam int PHASES     = 10;
   localparam int PHASE_BEATS = 120;
   localparam int STALL_CYCLES = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_KNOTS [PHASES] = '{7, 2, 32, 0, 1, 63, 4, 33, 16, 32};

   logic clock;
   logic reset;

   crce_req_if req_ch ();
   crce_rsp_if rsp_ch ();
   crce_csr_if csr_ch ();

   catmull_rom_curve_eval_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   crce_curve_scoreboard sb;
   int req_idle_pct;
   int rsp_idle_pct;
   int stall_asked;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // receiver: random back-pressure plus long hold-offs on request
   initial begin
      int stall_seen;
      int stall_left;
      stall_seen = 0;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready = 1'b0;
         end else if (stall_asked != stall_seen) begin
            stall_seen = stall_asked;
            stall_left = STALL_CYCLES;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_curve(rsp_ch.curve_value);
      end
   end

   // entered and left at a falling edge
   task automatic send(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                       logic signed [KNOT_W-1:0] val, logic [POS_W-1:0] pos);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.op         = op;
      req_ch.knot_index = idx;
      req_ch.knot_value = val;
      req_ch.position   = pos;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_request(op, idx, val, pos);
      @(negedge clock);
   endtask

   task automatic write_count(logic [CFG_W-1:0] n);
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_ch.valid      = 1'b1;
      csr_ch.knot_count = n;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_count(n);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // mostly knots in range and positions within [0,1], some raw noise
   task automatic random_beat();
      logic [OP_W-1:0]          op;
      logic [IDX_W-1:0]         idx;
      logic signed [KNOT_W-1:0] val;
      logic [POS_W-1:0]         pos;
      int                       pick;
      op  = ($urandom_range(99) < 45) ? OP_LOAD : OP_EVAL;
      idx = IDX_W'($urandom_range(TB_KNOTS - 1));
      if ($urandom_range(9) < 7) val = KNOT_W'($urandom_range(18000) - 1500);
      else val = KNOT_W'($urandom());
      pick = $urandom_range(19);
      if (pick < 13) pos = POS_W'($urandom_range(POS_ONE));
      else if (pick == 13) pos = '0;
      else if (pick < 17) pos = POS_ONE - POS_W'($urandom_range(3));
      else pos = POS_W'($urandom());
      send(op, idx, val, pos);
   endtask

   initial begin
      sb = new();
      req_idle_pct = 17;
      rsp_idle_pct = 54;
      stall_asked  = 0;
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_LOAD;
      req_ch.knot_index = '0;
      req_ch.knot_value = '0;
      req_ch.position   = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.knot_count = '0;
      reset = 1'b1;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // whole table written before any eval can read it
      for (int i = 0; i < TB_KNOTS; i++)
         send(OP_LOAD, IDX_W'(i), KNOT_W'($urandom_range(16384)), '0);

      // directed: value extremes, position edges, ignored fields
      send(OP_LOAD, 0, -16'sd32768, '0);
      send(OP_LOAD, 31, 16'sd32767, 17'h1FFFF);
      send(OP_LOAD, 3, 16'sd16384, '0);
      send(OP_EVAL, 0, '0, 17'd0);
      send(OP_EVAL, 0, '0, 17'd1);
      send(OP_EVAL, 0, '0, 17'd10923);
      send(OP_EVAL, 31, -16'sd1, 17'd32768);
      send(OP_EVAL, 0, '0, 17'd65535);
      send(OP_EVAL, 0, '0, POS_ONE);
      send(OP_EVAL, 0, '0, 17'd65537);
      send(OP_EVAL, 0, '0, 17'h1FFFF);
      send(OP_LOAD, 6, 16'sd32767, '0);
      send(OP_LOAD, 5, -16'sd32768, '0);
      send(OP_EVAL, 0, '0, 17'd60000);
      send(OP_EVAL, 0, '0, POS_ONE);
      send(OP_LOAD, 0, 16'sd0, '0);
      send(OP_EVAL, 0, '0, 17'd3000);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph >= 7) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (ph >= 4) begin
            req_idle_pct = 54;
            rsp_idle_pct = 17;
         end
         if (ph > 0) write_count(CFG_W'(PHASE_KNOTS[ph]));
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if ((ph == 7 || ph == 9) && k == 40) stall_asked++;
            random_beat();
         end
      end
      req_ch.valid = 1'b0;

      while (sb.pending() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (sb.mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
